// ----- src/u8d_pkg.sv -----
package u8d_pkg;

	localparam int unsigned ByteW = 8;
	localparam int unsigned CpW   = 23;
	localparam int unsigned RemW  = 2;

	// lead byte prefixes
	localparam logic [ByteW-1:0] Lead4Mask = 8'hF0;
	localparam logic [ByteW-1:0] Lead3Mask = 8'hE0;

	// continuation bytes still expected
	localparam logic [RemW-1:0] RemNone  = 2'd0;
	localparam logic [RemW-1:0] RemOne   = 2'd1;
	localparam logic [RemW-1:0] RemTwo   = 2'd2;
	localparam logic [RemW-1:0] RemThree = 2'd3;

	typedef struct packed {
		logic [RemW-1:0] remaining;
		logic [CpW-1:0]  partial;
	} dec_state_t;

	typedef struct packed {
		logic           emit;
		logic [CpW-1:0] code_point;
	} dec_result_t;

endpackage

// ----- src/utf8_byte_stream_decoder_unit.sv -----
// UTF-8 byte stream decoder: one byte per item in, one code point out when the
// last byte of a sequence arrives (ASCII bytes come out alone). It takes one
// byte every cycle unless the output register is full and stalled. The last
// byte of a sequence is held in the input register, and the decoded code point
// loads the output register as that byte advances. The sequence state register
// updates as each byte advances, so back pressure on the output only stalls the
// input when the output register is still full. No validation is done: malformed
// bytes decode by their prefix bits, and a truncated sequence absorbs the bytes after it.
module utf8_byte_stream_decoder_unit
	import u8d_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata    // [22:0] code_point, [23] zero
);

	logic             valid_s1;
	logic [ByteW-1:0] data_byte_s1;
	dec_state_t       state_q;
	dec_state_t       state_nxt;
	dec_result_t      res;
	logic             m_valid_q;
	logic [CpW-1:0]   code_point_q;
	logic             out_free;
	logic             advance;

	assign out_free = !m_valid_q || m_axis_tready;
	assign advance = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			data_byte_s1 <= s_axis_tdata;
		end
	end

	u8d_decode u_decode (
		.data_byte (data_byte_s1),
		.cur       (state_q),
		.nxt       (state_nxt),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				state_q <= state_nxt;
			end
			if (advance && res.emit) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.emit) begin
			code_point_q <= res.code_point;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata = {1'b0, code_point_q};

endmodule

// ----- src/u8d_decode.sv -----
module u8d_decode
	import u8d_pkg::*;
(
	input  logic [ByteW-1:0] data_byte,
	input  dec_state_t       cur,
	output dec_state_t       nxt,
	output dec_result_t      res
);

	logic [CpW-1:0] contrib;
	logic [CpW-1:0] sum;

	// weight the low seven bits by the position within the sequence
	always_comb begin
		unique case (cur.remaining)
			RemThree: contrib = {4'd0, data_byte[6:0], 12'd0};
			RemTwo:   contrib = {10'd0, data_byte[6:0], 6'd0};
			default:  contrib = {16'd0, data_byte[6:0]};
		endcase
	end

	assign sum = cur.partial + contrib;

	always_comb begin
		nxt = cur;
		res.emit = 1'b0;
		res.code_point = sum;
		if (cur.remaining != RemNone) begin
			nxt.remaining = cur.remaining - RemOne;
			if (cur.remaining == RemOne) begin
				res.emit = 1'b1;
				nxt.partial = '0;
			end else begin
				nxt.partial = sum;
			end
		end else if (!data_byte[7]) begin
			res.emit = 1'b1;
			res.code_point = {15'd0, data_byte};
		end else if ((data_byte & Lead4Mask) == Lead4Mask) begin
			nxt.remaining = RemThree;
			nxt.partial = {1'b0, data_byte[3:0], 18'd0};
		end else if ((data_byte & Lead3Mask) == Lead3Mask) begin
			nxt.remaining = RemTwo;
			nxt.partial = {6'd0, data_byte[4:0], 12'd0};
		end else begin
			nxt.remaining = RemOne;
			nxt.partial = {11'd0, data_byte[5:0], 6'd0};
		end
	end

endmodule

// ----- src/u8d_checker.sv -----
module u8d_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [7:0]  s_axis_tdata,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// input only stalls behind a full, stalled output
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without output back pressure");

	// an offered item waits unchanged until taken
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid && $stable(s_axis_tdata))
		else $error("offered item changed before it was taken");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !m_axis_tdata[23])
		else $error("code point exceeds 23 bits");

endmodule

bind utf8_byte_stream_decoder_unit u8d_checker u_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
